[rtl/psc_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psc_pkg
// Shared types, constants and helper functions of the pressure compensation.
// -----------------------------------------------------------------------------
package psc_pkg;

   localparam int CoeffW   = 16;
   localparam int ModelW   = 3;
   localparam int RawW     = 24;
   localparam int DtW      = 26;
   localparam int TempW    = 20;
   localparam int MulW     = 33;
   localparam int AddrW    = 5;
   localparam int DataW    = 32;
   localparam int StepW    = 3;

   // register indexes
   localparam logic [2:0] REG_SENS      = 3'd0;
   localparam logic [2:0] REG_OFFSET    = 3'd1;
   localparam logic [2:0] REG_SENS_TC   = 3'd2;
   localparam logic [2:0] REG_OFFSET_TC = 3'd3;
   localparam logic [2:0] REG_REF_TEMP  = 3'd4;
   localparam logic [2:0] REG_TEMP_SENS = 3'd5;
   localparam logic [2:0] REG_MODEL     = 3'd6;

   // sensor model codes
   localparam logic [ModelW-1:0] MODEL_1BAR  = 3'd0;
   localparam logic [ModelW-1:0] MODEL_2BAR  = 3'd1;
   localparam logic [ModelW-1:0] MODEL_5BAR  = 3'd2;
   localparam logic [ModelW-1:0] MODEL_14BAR = 3'd3;
   localparam logic [ModelW-1:0] MODEL_30BAR = 3'd4;

   localparam logic MODE_TEMP  = 1'b0;
   localparam logic MODE_PRESS = 1'b1;

   localparam int TempBase   = 2000;
   localparam int VeryColdT  = -1500;
   localparam int HotT       = 4500;
   localparam int TempLastStep  = 6;
   localparam int PressLastStep = 1;

   typedef enum logic [3:0] {
      OP_NONE = 4'd0,
      OP_DTC6 = 4'd1,
      OP_DT2  = 4'd2,
      OP_LO   = 4'd3,
      OP_VLO  = 4'd4,
      OP_HI   = 4'd5,
      OP_C4   = 4'd6,
      OP_C3   = 4'd7,
      OP_PL   = 4'd8,
      OP_PH   = 4'd9
   } op_type;

   typedef struct packed {
      logic   load;
      op_type op;
      logic   fin;
   } cmd_type;

   typedef struct packed {
      logic [CoeffW-1:0] c1;
      logic [CoeffW-1:0] c2;
      logic [CoeffW-1:0] c3;
      logic [CoeffW-1:0] c4;
      logic [CoeffW-1:0] c5;
      logic [CoeffW-1:0] c6;
      logic [ModelW-1:0] model;
   } cfg_type;

   // signed division by 2^k, truncating toward zero
   function automatic logic signed [63:0] tdiv_pow2(input logic signed [63:0] x,
                                                    input logic [5:0] k);
      logic signed [63:0] bias;
      bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
      return (x + bias) >>> k;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647)
         r = 32'sh7fffffff;
      else if (v < -64'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

[rtl/psc_csr.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psc_csr
// Calibration register file behind the apb-style port.
// -----------------------------------------------------------------------------
module psc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [psc_pkg::AddrW-1:0]   csr_paddr,
   input  logic [psc_pkg::DataW-1:0]   csr_pwdata,
   output logic [psc_pkg::DataW-1:0]   csr_prdata,
   output psc_pkg::cfg_type            cfg
);

   psc_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [2:0]       idx;

   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign idx   = csr_paddr[4:2];
   assign cfg   = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            psc_pkg::REG_SENS:      cfg_in.c1 = csr_pwdata[15:0];
            psc_pkg::REG_OFFSET:    cfg_in.c2 = csr_pwdata[15:0];
            psc_pkg::REG_SENS_TC:   cfg_in.c3 = csr_pwdata[15:0];
            psc_pkg::REG_OFFSET_TC: cfg_in.c4 = csr_pwdata[15:0];
            psc_pkg::REG_REF_TEMP:  cfg_in.c5 = csr_pwdata[15:0];
            psc_pkg::REG_TEMP_SENS: cfg_in.c6 = csr_pwdata[15:0];
            psc_pkg::REG_MODEL:     cfg_in.model = csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         psc_pkg::REG_SENS:      csr_prdata = {16'd0, cfg_ff.c1};
         psc_pkg::REG_OFFSET:    csr_prdata = {16'd0, cfg_ff.c2};
         psc_pkg::REG_SENS_TC:   csr_prdata = {16'd0, cfg_ff.c3};
         psc_pkg::REG_OFFSET_TC: csr_prdata = {16'd0, cfg_ff.c4};
         psc_pkg::REG_REF_TEMP:  csr_prdata = {16'd0, cfg_ff.c5};
         psc_pkg::REG_TEMP_SENS: csr_prdata = {16'd0, cfg_ff.c6};
         psc_pkg::REG_MODEL:     csr_prdata = {29'd0, cfg_ff.model};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         cfg_ff <= '0;
      else
         cfg_ff <= cfg_in;
   end

endmodule

[rtl/psc_ctrl.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psc_ctrl
// Sequencer: input load, multiplier steps, then final compute and output load.
// -----------------------------------------------------------------------------
module psc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_mode,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output psc_pkg::cmd_type cmd
);

   localparam int StepW = psc_pkg::StepW;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [psc_pkg::StepW-1:0]  step_ff, step_in;
   logic                       mode_ff, mode_in;
   logic                       outv_ff, outv_in;
   logic                       last_step;
   logic                       out_free;

   function automatic psc_pkg::op_type op_for(input logic m,
                                              input logic [psc_pkg::StepW-1:0] s);
      psc_pkg::op_type o;
      if (m == psc_pkg::MODE_PRESS) begin
         o = (s == 3'd0) ? psc_pkg::OP_PL : psc_pkg::OP_PH;
      end else begin
         case (s)
            3'd0:    o = psc_pkg::OP_DTC6;
            3'd1:    o = psc_pkg::OP_DT2;
            3'd2:    o = psc_pkg::OP_LO;
            3'd3:    o = psc_pkg::OP_VLO;
            3'd4:    o = psc_pkg::OP_HI;
            3'd5:    o = psc_pkg::OP_C4;
            3'd6:    o = psc_pkg::OP_C3;
            default: o = psc_pkg::OP_NONE;
         endcase
      end
      return o;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = outv_ff;
   assign out_free   = !outv_ff || rsp_tready;
   assign last_step  = (mode_ff == psc_pkg::MODE_PRESS) ?
                       (step_ff == StepW'(psc_pkg::PressLastStep)) :
                       (step_ff == StepW'(psc_pkg::TempLastStep));

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      mode_in  = mode_ff;
      outv_in  = outv_ff;
      cmd      = '{load: 1'b0, op: psc_pkg::OP_NONE, fin: 1'b0};
      if (outv_ff && rsp_tready)
         outv_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               mode_in  = req_mode;
               step_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.op = op_for(mode_ff, step_ff);
            if (last_step)
               state_in = ST_WAIT;
            else
               step_in = step_ff + 3'd1;
         end
         ST_WAIT: begin
            // last product lands in its register here
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.fin  = 1'b1;
               outv_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         mode_ff  <= 1'b0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         mode_ff  <= mode_in;
         outv_ff  <= outv_in;
      end
   end

endmodule

[rtl/psc_dp.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psc_dp
// Datapath: shared 33x33 multiplier, product registers, second-order
// correction, kept offset and sensitivity terms, and the output register.
// -----------------------------------------------------------------------------
module psc_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  psc_pkg::cmd_type                  cmd,
   input  psc_pkg::cfg_type                  cfg,
   input  logic                              in_mode,
   input  logic [psc_pkg::RawW-1:0]          in_raw,
   output logic                              out_kind,
   output logic signed [31:0]                out_value
);

   localparam int MulW  = psc_pkg::MulW;
   localparam int TempW = psc_pkg::TempW;

   logic                              mode_ff;
   logic [psc_pkg::RawW-1:0]          raw_ff;
   logic signed [psc_pkg::DtW-1:0]    dt_ff;
   logic signed [psc_pkg::TempW-1:0]  temp_ff;
   logic [49:0]                       dt2_ff;
   logic [39:0]                       lo_ff, vlo_ff, hi_ff;
   logic signed [43:0]                c4p_ff, c3p_ff;
   logic [56:0]                       pl_ff;
   logic signed [63:0]                acc_ff;
   logic signed [63:0]                prod_ff, prod_in;
   psc_pkg::op_type                   lastop_ff;
   logic signed [63:0]                off_ff, off_in, sens_ff, sens_in;
   logic                              kind_ff, kind_in;
   logic signed [31:0]                val_ff, val_in;

   logic signed [MulW-1:0]            op_a, op_b, tsh;
   logic signed [2*MulW-1:0]          mul_full;
   logic signed [psc_pkg::DtW-1:0]    dt_new;

   assign out_kind  = kind_ff;
   assign out_value = val_ff;

   assign dt_new = signed'({2'b00, in_raw}) - signed'({2'b00, cfg.c5, 8'd0});

   // operand select for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      tsh  = '0;
      case (cmd.op)
         psc_pkg::OP_DTC6: begin
            op_a = MulW'(dt_ff);
            op_b = signed'({17'd0, cfg.c6});
         end
         psc_pkg::OP_DT2: begin
            op_a = MulW'(dt_ff);
            op_b = MulW'(dt_ff);
         end
         psc_pkg::OP_LO: begin
            tsh  = MulW'(temp_ff) - MulW'(psc_pkg::TempBase);
            op_a = tsh;
            op_b = tsh;
         end
         psc_pkg::OP_VLO: begin
            tsh  = MulW'(temp_ff) - MulW'(psc_pkg::VeryColdT);
            op_a = tsh;
            op_b = tsh;
         end
         psc_pkg::OP_HI: begin
            tsh  = MulW'(temp_ff) - MulW'(psc_pkg::HotT);
            op_a = tsh;
            op_b = tsh;
         end
         psc_pkg::OP_C4: begin
            op_a = MulW'(dt_ff);
            op_b = signed'({17'd0, cfg.c4});
         end
         psc_pkg::OP_C3: begin
            op_a = MulW'(dt_ff);
            op_b = signed'({17'd0, cfg.c3});
         end
         psc_pkg::OP_PL: begin
            op_a = signed'({9'd0, raw_ff});
            op_b = signed'({1'b0, sens_ff[31:0]});
         end
         psc_pkg::OP_PH: begin
            op_a = signed'({9'd0, raw_ff});
            op_b = signed'({sens_ff[63], sens_ff[63:32]});
         end
         default: ;
      endcase
      mul_full = op_a * op_b;
      prod_in  = mul_full[63:0];
   end

   // input, product and output registers; previous product into its own register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= in_mode;
         raw_ff  <= in_raw;
         dt_ff   <= dt_new;
      end
      prod_ff <= prod_in;
      case (lastop_ff)
         psc_pkg::OP_DTC6: temp_ff <= TempW'(64'sd2000 + psc_pkg::tdiv_pow2(prod_ff, 6'd23));
         psc_pkg::OP_DT2:  dt2_ff  <= prod_ff[49:0];
         psc_pkg::OP_LO:   lo_ff   <= prod_ff[39:0];
         psc_pkg::OP_VLO:  vlo_ff  <= prod_ff[39:0];
         psc_pkg::OP_HI:   hi_ff   <= prod_ff[39:0];
         psc_pkg::OP_C4:   c4p_ff  <= prod_ff[43:0];
         psc_pkg::OP_C3:   c3p_ff  <= prod_ff[43:0];
         psc_pkg::OP_PL:   pl_ff   <= prod_ff[56:0];
         psc_pkg::OP_PH:   acc_ff  <= (prod_ff <<< 32) + signed'({7'd0, pl_ff});
         default: ;
      endcase
      kind_ff <= kind_in;
      val_ff  <= val_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lastop_ff <= psc_pkg::OP_NONE;
         off_ff    <= '0;
         sens_ff   <= '0;
      end else begin
         lastop_ff <= cmd.op;
         off_ff    <= off_in;
         sens_ff   <= sens_in;
      end
   end

   // final compute
   always_comb begin
      logic signed [63:0] t64, lo, vlo, hi, dt2, c4p, c3p, c1, c2;
      logic signed [63:0] off, sens, t2, off2, sens2, pv;
      logic               cold, vcold, hot, upd;
      t64   = 64'(temp_ff);
      lo    = signed'({24'd0, lo_ff});
      vlo   = signed'({24'd0, vlo_ff});
      hi    = signed'({24'd0, hi_ff});
      dt2   = signed'({14'd0, dt2_ff});
      c4p   = 64'(c4p_ff);
      c3p   = 64'(c3p_ff);
      c1    = signed'({48'd0, cfg.c1});
      c2    = signed'({48'd0, cfg.c2});
      cold  = t64 < 64'sd2000;
      vcold = t64 < -64'sd1500;
      hot   = t64 > 64'sd4500;
      off   = '0;
      sens  = '0;
      t2    = '0;
      off2  = '0;
      sens2 = '0;
      upd   = 1'b1;
      case (cfg.model)
         psc_pkg::MODEL_1BAR: begin
            off  = (c2 <<< 16) + psc_pkg::tdiv_pow2(c4p, 6'd7);
            sens = (c1 <<< 15) + psc_pkg::tdiv_pow2(c3p, 6'd8);
            if (cold) begin
               t2    = dt2 >>> 31;
               off2  = 64'sd3 * lo;
               sens2 = (64'sd7 * lo) >>> 3;
               if (vcold) sens2 = sens2 + 64'sd2 * vlo;
            end else if (hot) begin
               sens2 = -(hi >>> 3);
            end
         end
         psc_pkg::MODEL_2BAR: begin
            off  = (c2 <<< 17) + psc_pkg::tdiv_pow2(c4p, 6'd6);
            sens = (c1 <<< 16) + psc_pkg::tdiv_pow2(c3p, 6'd7);
            if (cold) begin
               t2    = dt2 >>> 31;
               off2  = (64'sd61 * lo) >>> 4;
               sens2 = 64'sd2 * lo;
               if (vcold) begin
                  off2  = off2 + 64'sd20 * vlo;
                  sens2 = sens2 + 64'sd12 * vlo;
               end
            end else if (hot) begin
               sens2 = -(hi >>> 3);
            end
         end
         psc_pkg::MODEL_5BAR: begin
            off  = (c2 <<< 18) + psc_pkg::tdiv_pow2(c4p, 6'd5);
            sens = (c1 <<< 17) + psc_pkg::tdiv_pow2(c3p, 6'd7);
            if (cold) begin
               t2    = (64'sd3 * dt2) >>> 33;
               off2  = (64'sd3 * lo) >>> 3;
               sens2 = (64'sd7 * lo) >>> 3;
               if (vcold) sens2 = sens2 + 64'sd3 * vlo;
            end
         end
         psc_pkg::MODEL_14BAR, psc_pkg::MODEL_30BAR: begin
            off  = (c2 <<< 16) + psc_pkg::tdiv_pow2(c4p, 6'd7);
            sens = (c1 <<< 15) + psc_pkg::tdiv_pow2(c3p, 6'd8);
            if (cold) begin
               t2    = (64'sd3 * dt2) >>> 33;
               off2  = (64'sd3 * lo) >>> 1;
               sens2 = (64'sd5 * lo) >>> 3;
               if (vcold) begin
                  off2  = off2 + 64'sd7 * vlo;
                  sens2 = sens2 + 64'sd4 * vlo;
               end
            end else begin
               t2   = (64'sd7 * dt2) >>> 37;
               off2 = lo >>> 4;
            end
         end
         default: upd = 1'b0;
      endcase
      pv = psc_pkg::tdiv_pow2(psc_pkg::tdiv_pow2(acc_ff, 6'd21) - off_ff, 6'd15);

      off_in  = off_ff;
      sens_in = sens_ff;
      kind_in = kind_ff;
      val_in  = val_ff;
      if (cmd.fin) begin
         kind_in = mode_ff;
         if (mode_ff == psc_pkg::MODE_PRESS) begin
            val_in = psc_pkg::sat32(pv);
         end else begin
            val_in = psc_pkg::sat32(t64 - t2);
            if (upd) begin
               off_in  = off - off2;
               sens_in = sens - sens2;
            end
         end
      end
   end

endmodule

[rtl/pressure_sensor_compensation.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pressure_sensor_compensation
// Second-order compensation of raw temperature and pressure conversions.
// -----------------------------------------------------------------------------
//  channel   direction  contents
//  req       in         tdata: raw_value[23:0]; tuser: mode
//  rsp       out        tdata: result_value[31:0]; tuser: result_kind
//  csr       in/out     apb-style, seven calibration registers at 4*i
//
//  each request is accepted and then runs one step per product on the single
//  shared 33x33 multiplier, then a wait and a final cycle; the next request
//  is taken once the final cycle is done.
//  reset is synchronous; kept offset and sensitivity terms clear to zero.
//  the next request is taken while a result still waits in the output register;
//  the final cycle of that request stalls until the output register is free.
// -----------------------------------------------------------------------------
module pressure_sensor_compensation (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,   // raw_value[23:0]
   input  logic                       req_tuser,   // mode
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,   // result_value[31:0]
   output logic                       rsp_tuser,   // result_kind
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [psc_pkg::AddrW-1:0]  csr_paddr,
   input  logic [psc_pkg::DataW-1:0]  csr_pwdata,
   output logic [psc_pkg::DataW-1:0]  csr_prdata,
   output logic                       csr_pready
);

   psc_pkg::cmd_type    cmd;
   psc_pkg::cfg_type    cfg;
   logic signed [31:0]  value;

   assign csr_pready = 1'b1;
   assign rsp_tdata  = value;

   psc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   psc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   psc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .in_mode   (req_tuser),
      .in_raw    (req_tdata),
      .out_kind  (rsp_tuser),
      .out_value (value)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   a_busy_whole_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> ##4 !req_tready)
      else $error("item finished too early");

   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without work");

endmodule
